### rtl/core/ctsc_pkg.sv
// shared constants, types and helpers of the clock timer setting calculator
package ctsc_pkg;

	localparam int unsigned KW = 34;
	localparam int unsigned SUM_W = 48;
	localparam int unsigned DIV1_NW = 35;
	localparam int unsigned DIV2_NW = 64;

	localparam logic [31:0] RECIP_125 = 32'd2199023255;
	localparam int unsigned RECIP_125_SH = 38;
	localparam logic [31:0] RECIP_DAY = 32'd3335999723;
	localparam int unsigned RECIP_DAY_SH = 48;

	localparam logic [26:0] DAY_MS = 27'd86400000;
	localparam logic [16:0] DAY_MS_ODD = 17'd84375;
	localparam logic [16:0] DAY_S = 17'd86400;
	localparam logic [16:0] PERIOD_MAX = 17'd96000;
	localparam logic [4:0] PREC_MAX = 5'd30;
	localparam logic [2:0] PRESCALE_NONE = 3'd7;

	typedef struct packed {
		logic req_valid;
		logic [2:0] prescale;
		logic [15:0] reload;
		logic [16:0] pulse_t;
		logic [16:0] charge_t;
		logic [7:0] offset;
		logic [2:0] flags;
		logic [KW-1:0] k;
		logic [KW-1:0] dmag;
		logic dpos;
		logic dzero;
		logic [4:0] prec;
	} side_t;

	function automatic logic [5:0] bit_len32(input logic [31:0] v);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				n = 6'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

### rtl/core/clock_timer_setting_calculator_top.sv
// top level of the clock timer setting calculator pipeline
// throughput: one request per cycle while the skid stage is empty;
// the two divider chains (35 and 64 stages) set the depth
// s_axis_tready is a register: it stays low while a result waits in the skid stage
// reset: arst_n clears all valid bits and the output and skid stages; payload is not reset
module clock_timer_setting_calculator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// period_ms, pulse_ms, charge_ms, drift_fix, drift_negative, in_voltage_sel,
	// out_voltage_sel, pulse_polarity
	input  logic [71:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// request_valid, prescale_sel, reload_ticks, pulse_ticks, charge_ticks, cal_period,
	// cal_negative, cal_offset, cal_precision, in_voltage_out, out_voltage_out, polarity_out
	output logic [159:0] m_axis_tdata
);

	typedef struct packed {
		logic        polarity_out;
		logic        out_voltage_out;
		logic        in_voltage_out;
		logic [30:0] cal_precision;
		logic [7:0]  cal_offset;
		logic        cal_negative;
		logic [62:0] cal_period;
		logic [16:0] charge_ticks;
		logic [16:0] pulse_ticks;
		logic [15:0] reload_ticks;
		logic [2:0]  prescale_sel;
		logic        request_valid;
	} res_t;

	localparam int unsigned SIDE_W = $bits(ctsc_pkg::side_t);

	logic ce;
	logic out_v_q, skid_v_q;
	res_t out_q, skid_q;

	// input fields
	logic [16:0] in_period, in_pulse, in_charge, in_fix;
	logic [2:0]  in_p;
	logic        in_ok;

	assign in_period = s_axis_tdata[16:0];
	assign in_pulse  = s_axis_tdata[33:17];
	assign in_charge = s_axis_tdata[50:34];
	assign in_fix    = s_axis_tdata[67:51];

	always_comb begin
		if (in_period < 17'd1500) begin
			in_p = 3'd0;
		end else if (in_period < 17'd3000) begin
			in_p = 3'd1;
		end else if (in_period < 17'd6000) begin
			in_p = 3'd2;
		end else if (in_period < 17'd12000) begin
			in_p = 3'd3;
		end else if (in_period < 17'd24000) begin
			in_p = 3'd4;
		end else if (in_period < 17'd48000) begin
			in_p = 3'd5;
		end else begin
			in_p = ctsc_pkg::PRESCALE_NONE;
		end
	end

	assign in_ok = (in_period != 17'd0) && (in_pulse != 17'd0)
		&& (in_period <= ctsc_pkg::PERIOD_MAX) && !in_fix[16]
		&& ({1'b0, in_period} > ({1'b0, in_charge} + {1'b0, in_pulse}));

	assign ce = !skid_v_q;
	assign s_axis_tready = ce;

	// stage registers
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13,
		v_s14, v_s15, v_s16, v_s17;

	logic [16:0] period_s1, pulse_s1, charge_s1, fix_s1;
	logic [2:0]  p_s1, flags_s1;
	logic        fneg_s1, ok_s1;

	logic [16:0] period_s2, fix_s2;
	logic [2:0]  p_s2, flags_s2;
	logic        fneg_s2, ok_s2;
	logic [28:0] ar_s2, ap_s2, ac_s2;
	logic [22:0] qer_s2, qep_s2, qec_s2;

	logic [16:0] period_s3, fix_s3;
	logic [2:0]  p_s3, flags_s3;
	logic        fneg_s3, ok_s3;
	logic [22:0] q_s3, qp_s3, qc_s3;

	logic [16:0] fix_s4, r_s4, qp_s4, qc_s4;
	logic [2:0]  p_s4, flags_s4;
	logic        fneg_s4, ok_s4;
	logic [22:0] q_s4;

	logic [2:0]  p_s5, flags_s5;
	logic        fneg_s5, ok_s5;
	logic [16:0] qp_s5, qc_s5;
	logic [15:0] reload_s5;
	logic [39:0] fq_s5;
	logic [33:0] fr_s5, r86_s5;

	logic [2:0]  p_s6, flags_s6;
	logic        fneg_s6, ok_s6;
	logic [16:0] qp_s6, qc_s6;
	logic [15:0] reload_s6;
	logic [46:0] fq2_s6;
	logic [33:0] r86_s6;
	logic [30:0] frr_s6;
	logic [24:0] qe2_s6;

	logic [2:0]  p_s7, flags_s7;
	logic        fneg_s7, ok_s7;
	logic [16:0] qp_s7, qc_s7;
	logic [15:0] reload_s7;
	logic [46:0] fq2_s7;
	logic [33:0] r86_s7;
	logic [24:0] m1_s7;

	logic [2:0]  p_s8, flags_s8;
	logic        ok_s8;
	logic [16:0] qp_s8, qc_s8;
	logic [15:0] reload_s8;
	logic [ctsc_pkg::SUM_W-1:0] s_s8;

	logic [2:0]  p_s9, flags_s9;
	logic        ok_s9, sneg_s9;
	logic [16:0] qp_s9, qc_s9;
	logic [15:0] reload_s9;
	logic [ctsc_pkg::SUM_W-1:0] smag_s9;
	logic [ctsc_pkg::KW-1:0] k_s9;
	logic [30:0] xo_s9;

	logic [2:0]  p_s10, flags_s10;
	logic        ok_s10, sneg_s10;
	logic [16:0] qp_s10, qc_s10;
	logic [15:0] reload_s10;
	logic [ctsc_pkg::SUM_W-1:0] smag_s10;
	logic [ctsc_pkg::KW-1:0] k_s10;
	logic [30:0] xo_s10;
	logic [14:0] qe3_s10;

	logic [2:0]  p_s11, flags_s11;
	logic        ok_s11, sneg_s11;
	logic [16:0] qp_s11, qc_s11;
	logic [15:0] reload_s11;
	logic [ctsc_pkg::SUM_W-1:0] smag_s11;
	logic [ctsc_pkg::KW-1:0] k_s11;
	logic [14:0] om_s11;
	logic [7:0]  off_s11;

	logic [2:0]  p_s12, flags_s12;
	logic        ok_s12, sneg_s12;
	logic [16:0] qp_s12, qc_s12;
	logic [15:0] reload_s12;
	logic [ctsc_pkg::SUM_W-1:0] smag_s12;
	logic [ctsc_pkg::KW-1:0] k_s12;
	logic [7:0]  off_s12;
	logic [48:0] ko_s12;

	logic [2:0]  p_s13, flags_s13;
	logic        ok_s13;
	logic [16:0] qp_s13, qc_s13;
	logic [15:0] reload_s13;
	logic [ctsc_pkg::KW-1:0] k_s13, dmag_s13;
	logic [7:0]  off_s13;
	logic        dpos_s13, dzero_s13;

	ctsc_pkg::side_t side_s14, side_s15, side_s16, side1, side1_p, side2;
	logic [ctsc_pkg::DIV1_NW-1:0] dvd_s14, q1;
	logic [ctsc_pkg::DIV2_NW-1:0] dvd_s16, q2;
	logic v1, v2;
	res_t res_s17;

	// stage datapath
	logic [60:0] pr_r, pr_p, pr_c;
	logic [28:0] a_r, a_p, a_c, rm_r, rm_p, rm_c;
	logic [31:0] rmd;
	logic [62:0] pr2;
	logic [30:0] frr;
	logic [30:0] rm2;
	logic [47:0] u, s;
	logic [ctsc_pkg::SUM_W-1:0] smag;
	logic [ctsc_pkg::KW-1:0] kk;
	logic [62:0] pr3;
	logic [31:0] rm3;
	logic [14:0] om;
	logic [49:0] dd;
	logic [31:0] t32, at32;
	logic [5:0]  blen;
	logic [4:0]  prec;
	logic [ctsc_pkg::DIV2_NW-1:0] vmag;
	logic        vpos;

	assign a_r = {period_s1, 12'b0} >> p_s1;
	assign a_p = {pulse_s1, 12'b0} >> p_s1;
	assign a_c = {charge_s1, 12'b0} >> p_s1;
	assign pr_r = 61'(a_r) * 61'(ctsc_pkg::RECIP_125);
	assign pr_p = 61'(a_p) * 61'(ctsc_pkg::RECIP_125);
	assign pr_c = 61'(a_c) * 61'(ctsc_pkg::RECIP_125);

	assign rm_r = ar_s2 - 29'(30'(qer_s2) * 30'd125);
	assign rm_p = ap_s2 - 29'(30'(qep_s2) * 30'd125);
	assign rm_c = ac_s2 - 29'(30'(qec_s2) * 30'd125);

	assign rmd = {period_s3, 15'b0} - ((32'(q_s3) * 32'd1000) << p_s3);

	assign frr = 31'((fr_s5 + 34'd500) >> 3);
	assign pr2 = 63'(frr) * 63'(ctsc_pkg::RECIP_125);

	assign rm2 = frr_s6 - 31'(32'(qe2_s6) * 32'd125);

	assign u = 48'(fq2_s7) + 48'(m1_s7);
	assign s = fneg_s7 ? (48'(r86_s7) - u) : (48'(r86_s7) + u);

	assign smag = s_s8[ctsc_pkg::SUM_W-1] ? (48'd0 - s_s8) : s_s8;
	assign kk   = {7'b0, ctsc_pkg::DAY_MS} << p_s8;

	assign pr3 = 63'(xo_s9) * 63'(ctsc_pkg::RECIP_DAY);

	assign rm3 = 32'(xo_s10) - (32'(qe3_s10) * 32'(ctsc_pkg::DAY_MS_ODD));
	assign om  = qe3_s10 + 15'(rm3 >= 32'(ctsc_pkg::DAY_MS_ODD));

	assign dd = 50'(smag_s12) - 50'(ko_s12);

	assign t32  = side1.dpos ? q1[31:0] : (32'd0 - q1[31:0]);
	assign at32 = ((t32 != 32'd0) && !t32[31]) ? t32 : (32'd0 - t32);
	assign blen = ctsc_pkg::bit_len32(at32);
	always_comb begin
		if (side1.dzero) begin
			prec = ctsc_pkg::PREC_MAX;
		end else if (blen > 6'(ctsc_pkg::PREC_MAX)) begin
			prec = 5'd0;
		end else begin
			prec = ctsc_pkg::PREC_MAX - blen[4:0];
		end
	end

	always_comb begin
		side1_p = side1;
		side1_p.prec = prec;
	end

	assign vmag = side2.dzero ? '0 : q2;
	assign vpos = side2.dpos && (vmag != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11, v_s12, v_s13,
				v_s14, v_s15, v_s16, v_s17} <= '0;
		end else if (ce) begin
			v_s1  <= s_axis_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v1;
			v_s16 <= v_s15;
			v_s17 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			// request fields and prescaler
			period_s1 <= in_period;
			pulse_s1  <= in_pulse;
			charge_s1 <= in_charge;
			fix_s1    <= in_fix;
			fneg_s1   <= s_axis_tdata[68];
			flags_s1  <= s_axis_tdata[71:69];
			p_s1      <= in_p;
			ok_s1     <= in_ok;
			// reciprocal estimates of the tick quotients
			period_s2 <= period_s1;
			fix_s2    <= fix_s1;
			p_s2      <= p_s1;
			flags_s2  <= flags_s1;
			fneg_s2   <= fneg_s1;
			ok_s2     <= ok_s1;
			ar_s2     <= a_r;
			ap_s2     <= a_p;
			ac_s2     <= a_c;
			qer_s2    <= pr_r[60:ctsc_pkg::RECIP_125_SH];
			qep_s2    <= pr_p[60:ctsc_pkg::RECIP_125_SH];
			qec_s2    <= pr_c[60:ctsc_pkg::RECIP_125_SH];
			// correction
			period_s3 <= period_s2;
			fix_s3    <= fix_s2;
			p_s3      <= p_s2;
			flags_s3  <= flags_s2;
			fneg_s3   <= fneg_s2;
			ok_s3     <= ok_s2;
			q_s3      <= qer_s2 + 23'(rm_r >= 29'd125);
			qp_s3     <= qep_s2 + 23'(rm_p >= 29'd125);
			qc_s3     <= qec_s2 + 23'(rm_c >= 29'd125);
			// remainder of the period conversion
			fix_s4    <= fix_s3;
			p_s4      <= p_s3;
			flags_s4  <= flags_s3;
			fneg_s4   <= fneg_s3;
			ok_s4     <= ok_s3;
			q_s4      <= q_s3;
			qp_s4     <= qp_s3[16:0];
			qc_s4     <= qc_s3[16:0];
			r_s4      <= rmd[16:0];
			// drift products
			p_s5      <= p_s4;
			flags_s5  <= flags_s4;
			fneg_s5   <= fneg_s4;
			ok_s5     <= ok_s4;
			qp_s5     <= qp_s4;
			qc_s5     <= qc_s4;
			reload_s5 <= q_s4[15:0];
			fq_s5     <= 40'(fix_s4) * 40'(q_s4);
			fr_s5     <= 34'(fix_s4) * 34'(r_s4);
			r86_s5    <= 34'(r_s4) * 34'(ctsc_pkg::DAY_S);
			// rounded drift remainder over 1000
			p_s6      <= p_s5;
			flags_s6  <= flags_s5;
			fneg_s6   <= fneg_s5;
			ok_s6     <= ok_s5;
			qp_s6     <= qp_s5;
			qc_s6     <= qc_s5;
			reload_s6 <= reload_s5;
			fq2_s6    <= 47'(fq_s5) << p_s5;
			r86_s6    <= r86_s5;
			frr_s6    <= frr;
			qe2_s6    <= pr2[62:ctsc_pkg::RECIP_125_SH];
			p_s7      <= p_s6;
			flags_s7  <= flags_s6;
			fneg_s7   <= fneg_s6;
			ok_s7     <= ok_s6;
			qp_s7     <= qp_s6;
			qc_s7     <= qc_s6;
			reload_s7 <= reload_s6;
			fq2_s7    <= fq2_s6;
			r86_s7    <= r86_s6;
			m1_s7     <= qe2_s6 + 25'(rm2 >= 31'd125);
			// signed daily sum
			p_s8      <= p_s7;
			flags_s8  <= flags_s7;
			ok_s8     <= ok_s7;
			qp_s8     <= qp_s7;
			qc_s8     <= qc_s7;
			reload_s8 <= reload_s7;
			s_s8      <= s;
			// rounded whole-tick offset
			p_s9      <= p_s8;
			flags_s9  <= flags_s8;
			ok_s9     <= ok_s8;
			qp_s9     <= qp_s8;
			qc_s9     <= qc_s8;
			reload_s9 <= reload_s8;
			sneg_s9   <= s_s8[ctsc_pkg::SUM_W-1];
			smag_s9   <= smag;
			k_s9      <= kk;
			xo_s9     <= 31'(((smag + 48'(kk >> 1)) >> 10) >> p_s8);
			p_s10      <= p_s9;
			flags_s10  <= flags_s9;
			ok_s10     <= ok_s9;
			qp_s10     <= qp_s9;
			qc_s10     <= qc_s9;
			reload_s10 <= reload_s9;
			sneg_s10   <= sneg_s9;
			smag_s10   <= smag_s9;
			k_s10      <= k_s9;
			xo_s10     <= xo_s9;
			qe3_s10    <= pr3[62:ctsc_pkg::RECIP_DAY_SH];
			p_s11      <= p_s10;
			flags_s11  <= flags_s10;
			ok_s11     <= ok_s10;
			qp_s11     <= qp_s10;
			qc_s11     <= qc_s10;
			reload_s11 <= reload_s10;
			sneg_s11   <= sneg_s10;
			smag_s11   <= smag_s10;
			k_s11      <= k_s10;
			om_s11     <= om;
			off_s11    <= sneg_s10 ? (8'd0 - om[7:0]) : om[7:0];
			// remainder term
			p_s12      <= p_s11;
			flags_s12  <= flags_s11;
			ok_s12     <= ok_s11;
			qp_s12     <= qp_s11;
			qc_s12     <= qc_s11;
			reload_s12 <= reload_s11;
			sneg_s12   <= sneg_s11;
			smag_s12   <= smag_s11;
			k_s12      <= k_s11;
			off_s12    <= off_s11;
			ko_s12     <= 49'(k_s11) * 49'(om_s11);
			p_s13      <= p_s12;
			flags_s13  <= flags_s12;
			ok_s13     <= ok_s12;
			qp_s13     <= qp_s12;
			qc_s13     <= qc_s12;
			reload_s13 <= reload_s12;
			k_s13      <= k_s12;
			off_s13    <= off_s12;
			dmag_s13   <= 34'(dd[49] ? (50'd0 - dd) : dd);
			dzero_s13  <= dd == 50'd0;
			dpos_s13   <= (dd != 50'd0) && (dd[49] == sneg_s12);
			// ratio division operands
			side_s14.req_valid <= ok_s13;
			side_s14.prescale  <= p_s13;
			side_s14.reload    <= reload_s13;
			side_s14.pulse_t   <= qp_s13;
			side_s14.charge_t  <= qc_s13;
			side_s14.offset    <= off_s13;
			side_s14.flags     <= flags_s13;
			side_s14.k         <= k_s13;
			side_s14.dmag      <= dmag_s13;
			side_s14.dpos      <= dpos_s13;
			side_s14.dzero     <= dzero_s13;
			side_s14.prec      <= '0;
			dvd_s14 <= 35'(k_s13) + 35'(dmag_s13 >> 1);
			// precision from the ratio
			side_s15 <= side1_p;
			// period division operands
			side_s16 <= side_s15;
			dvd_s16  <= (64'(side_s15.k) << side_s15.prec) + 64'(side_s15.dmag >> 1);
			// result assembly
			res_s17.request_valid   <= side2.req_valid;
			res_s17.prescale_sel    <= side2.prescale;
			res_s17.reload_ticks    <= side2.reload;
			res_s17.pulse_ticks     <= side2.pulse_t;
			res_s17.charge_ticks    <= side2.charge_t;
			res_s17.cal_period      <= vmag[62:0];
			res_s17.cal_negative    <= !vpos;
			res_s17.cal_offset      <= side2.offset;
			res_s17.cal_precision   <= 31'd1 << side2.prec;
			res_s17.in_voltage_out  <= side2.flags[0];
			res_s17.out_voltage_out <= side2.flags[1];
			res_s17.polarity_out    <= side2.flags[2];
		end
	end

	ctsc_div #(
		.NW(ctsc_pkg::DIV1_NW),
		.DW(ctsc_pkg::KW),
		.SW(SIDE_W)
	) u_div_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (v_s14),
		.dividend (dvd_s14),
		.divisor  (side_s14.dmag),
		.side_in  (side_s14),
		.out_valid(v1),
		.quotient (q1),
		.side_out (side1)
	);

	ctsc_div #(
		.NW(ctsc_pkg::DIV2_NW),
		.DW(ctsc_pkg::KW),
		.SW(SIDE_W)
	) u_div_period (
		.clk      (clk),
		.arst_n   (arst_n),
		.ce       (ce),
		.in_valid (v_s16),
		.dividend (dvd_s16),
		.divisor  (side_s16.dmag),
		.side_in  (side_s16),
		.out_valid(v2),
		.quotient (q2),
		.side_out (side2)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= v_s17;
			end
		end else if (ce && v_s17) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : res_s17;
		end else if (ce && v_s17) begin
			skid_q <= res_s17;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full while output stage empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
		else $error("skid stage filled without a stalled transfer");

	a_prec_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> $onehot(out_q.cal_precision))
		else $error("calibration precision not a power of two");

	a_prescale_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.prescale_sel != 3'd6))
		else $error("prescaler exponent out of range");

endmodule

### rtl/core/ctsc_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
module ctsc_div #(
	parameter int unsigned NW = 35,
	parameter int unsigned DW = 34,
	parameter int unsigned SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          ce,
	input  logic          in_valid,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quotient,
	output logic [SW-1:0] side_out
);

	logic [NW-1:0] work_s [1:NW];
	logic [DW-1:0] rem_s  [1:NW-1];
	logic [DW-1:0] dvs_s  [1:NW-1];
	logic [SW-1:0] side_s [1:NW];
	logic [NW:1]   vld_s;

	for (genvar i = 1; i <= NW; i++) begin : g_stg
		logic [NW-1:0] pw;
		logic [DW-1:0] pr;
		logic [DW-1:0] pd;
		logic [SW-1:0] ps;
		logic          pv;
		logic [DW:0]   cand;
		logic [DW:0]   diff;
		logic          ge;

		if (i == 1) begin : g_first
			assign pw = dividend;
			assign pr = '0;
			assign pd = divisor;
			assign ps = side_in;
			assign pv = in_valid;
		end else begin : g_next
			assign pw = work_s[i-1];
			assign pr = rem_s[i-1];
			assign pd = dvs_s[i-1];
			assign ps = side_s[i-1];
			assign pv = vld_s[i-1];
		end

		assign cand = {pr, pw[NW-1]};
		assign ge   = cand >= {1'b0, pd};
		assign diff = cand - {1'b0, pd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (ce) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				work_s[i] <= {pw[NW-2:0], ge};
				side_s[i] <= ps;
			end
		end

		if (i < NW) begin : g_rem
			always_ff @(posedge clk) begin
				if (ce) begin
					rem_s[i] <= ge ? diff[DW-1:0] : cand[DW-1:0];
					dvs_s[i] <= pd;
				end
			end
		end
	end

	assign out_valid = vld_s[NW];
	assign quotient  = work_s[NW];
	assign side_out  = side_s[NW];

endmodule

### verif/tb.sv
// self-checking testbench for the clock timer setting calculator: predicted versus returned settings
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic        polarity;
		logic        out_volt;
		logic        in_volt;
		logic        drift_neg;
		logic [16:0] drift_fix;
		logic [16:0] charge_ms;
		logic [16:0] pulse_ms;
		logic [16:0] period_ms;
	} request_t;

	typedef struct packed {
		logic        polarity;
		logic        out_volt;
		logic        in_volt;
		logic [30:0] cal_precision;
		logic [7:0]  cal_offset;
		logic        cal_negative;
		logic [62:0] cal_period;
		logic [16:0] charge_ticks;
		logic [16:0] pulse_ticks;
		logic [15:0] reload_ticks;
		logic [2:0]  prescale_sel;
		logic        request_valid;
	} settings_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [71:0]  s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [159:0] m_axis_tdata;

	settings_t pending_settings[$];
	int        errors = 0;
	int        sent = 0;
	int        checked = 0;
	int        src_idle_pct = 0;
	int        snk_idle_pct = 0;

	clock_timer_setting_calculator_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1000000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [63:0] rnd_udiv(input logic [63:0] a, input logic [63:0] b);
		if (b == 64'd0) begin
			return 64'd0;
		end
		return (a + (b >> 1)) / b;
	endfunction

	function automatic logic [63:0] abs64(input longint v);
		return v < 0 ? 64'd0 - 64'(v) : 64'(v);
	endfunction

	function automatic longint rnd_sdiv(input longint a, input longint b);
		longint m;
		m = longint'(rnd_udiv(abs64(a), abs64(b)));
		return ((a > 0 && b > 0) || (a < 0 && b < 0)) ? m : -m;
	endfunction

	function automatic settings_t timer_settings(input request_t rq);
		settings_t   st;
		logic [2:0]  p;
		logic [31:0] dv, num, q, r, t, at;
		logic [63:0] tm, dmag, vmag;
		longint      f, scale, k, s, off, d;
		int          len, prec;
		p = 3'd7;
		for (int i = 5; i >= 0; i--) begin
			if (rq.period_ms < (750 << (i + 1))) begin
				p = 3'(i);
			end
		end
		dv = 32'd1000 << p;
		num = 32'(rq.period_ms) * 32'd32768;
		q = num / dv;
		r = num % dv;
		f = rq.drift_neg ? -longint'(rq.drift_fix) : longint'(rq.drift_fix);
		scale = longint'(1) << p;
		k = 64'sd86400000 * scale;
		s = f * longint'(q) * scale + rnd_sdiv(f * longint'(r), 1000) + 64'sd86400 * longint'(r);
		off = rnd_sdiv(s, k);
		d = s - k * off;
		vmag = '0;
		prec = 30;
		st = '0;
		st.cal_negative = 1'b1;
		if (d != 0) begin
			dmag = abs64(d);
			tm = rnd_udiv(64'(k), dmag);
			t = d > 0 ? tm[31:0] : 32'd0 - tm[31:0];
			at = (t != 0 && t < 32'h8000_0000) ? t : 32'd0 - t;
			len = 0;
			for (int i = 0; i < 32; i++) begin
				if (at[i]) begin
					len = i + 1;
				end
			end
			prec = len > 30 ? 0 : 30 - len;
			vmag = rnd_udiv(64'(k) << prec, dmag);
			st.cal_negative = !(d > 0 && vmag != 0);
		end
		st.request_valid = rq.period_ms != 0 && rq.pulse_ms != 0 && rq.period_ms <= 96000
			&& rq.drift_fix < 65536 && 32'(rq.period_ms) > 32'(rq.charge_ms) + 32'(rq.pulse_ms);
		st.prescale_sel = p;
		st.reload_ticks = q[15:0];
		st.pulse_ticks = 17'((32'(rq.pulse_ms) * 32'd32768) / dv);
		st.charge_ticks = 17'((32'(rq.charge_ms) * 32'd32768) / dv);
		st.cal_period = vmag[62:0];
		st.cal_offset = off[7:0];
		st.cal_precision = 31'(64'd1 << prec);
		st.in_volt = rq.in_volt;
		st.out_volt = rq.out_volt;
		st.polarity = rq.polarity;
		return st;
	endfunction

	task automatic send_request(input request_t rq);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= rq;
		do @(posedge clk); while (!s_axis_tready);
		pending_settings.push_back(timer_settings(rq));
		sent++;
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		settings_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (pending_settings.size() == 0) begin
				$error("unexpected transfer %h", m_axis_tdata);
				errors++;
			end else begin
				want = pending_settings.pop_front();
				checked++;
				if (got.request_valid !== want.request_valid) begin
					$error("request_valid exp %0d got %0d", want.request_valid, got.request_valid);
					errors++;
				end
				if (got.prescale_sel !== want.prescale_sel) begin
					$error("prescale_sel exp %0d got %0d", want.prescale_sel, got.prescale_sel);
					errors++;
				end
				if (got.reload_ticks !== want.reload_ticks) begin
					$error("reload_ticks exp %0d got %0d", want.reload_ticks, got.reload_ticks);
					errors++;
				end
				if (got.pulse_ticks !== want.pulse_ticks) begin
					$error("pulse_ticks exp %0d got %0d", want.pulse_ticks, got.pulse_ticks);
					errors++;
				end
				if (got.charge_ticks !== want.charge_ticks) begin
					$error("charge_ticks exp %0d got %0d", want.charge_ticks, got.charge_ticks);
					errors++;
				end
				if (got.cal_period !== want.cal_period) begin
					$error("cal_period exp %0d got %0d", want.cal_period, got.cal_period);
					errors++;
				end
				if (got.cal_negative !== want.cal_negative) begin
					$error("cal_negative exp %0d got %0d", want.cal_negative, got.cal_negative);
					errors++;
				end
				if (got.cal_offset !== want.cal_offset) begin
					$error("cal_offset exp %0d got %0d", $signed(want.cal_offset),
						$signed(got.cal_offset));
					errors++;
				end
				if (got.cal_precision !== want.cal_precision) begin
					$error("cal_precision exp %0d got %0d", want.cal_precision, got.cal_precision);
					errors++;
				end
				if (got.in_volt !== want.in_volt) begin
					$error("in_voltage_out exp %0d got %0d", want.in_volt, got.in_volt);
					errors++;
				end
				if (got.out_volt !== want.out_volt) begin
					$error("out_voltage_out exp %0d got %0d", want.out_volt, got.out_volt);
					errors++;
				end
				if (got.polarity !== want.polarity) begin
					$error("polarity_out exp %0d got %0d", want.polarity, got.polarity);
					errors++;
				end
			end
		end
	end

	function automatic request_t make_request(input int per, input int pul, input int chg,
		input int fix, input bit neg, input bit [2:0] flags);
		request_t rq;
		rq.period_ms = 17'(per);
		rq.pulse_ms = 17'(pul);
		rq.charge_ms = 17'(chg);
		rq.drift_fix = 17'(fix);
		rq.drift_neg = neg;
		{rq.polarity, rq.out_volt, rq.in_volt} = flags;
		return rq;
	endfunction

	task automatic test_directed();
		int edges[19] = '{0, 1, 749, 750, 1499, 1500, 2999, 3000, 5999, 6000, 11999, 12000,
			23999, 24000, 47999, 48000, 96000, 96001, 131071};
		foreach (edges[i]) begin
			send_request(make_request(edges[i], 1, 0, i * 3000, i[0], 3'(i)));
		end
		// exact conversion with no drift gives a zero remainder term
		send_request(make_request(125, 10, 10, 0, 1'b0, 3'b000));
		send_request(make_request(5000, 0, 100, 65535, 1'b1, 3'b111));
		send_request(make_request(5000, 131071, 131071, 65536, 1'b0, 3'b101));
		send_request(make_request(131071, 131071, 131071, 131071, 1'b1, 3'b111));
		send_request(make_request(1000, 500, 499, 65535, 1'b0, 3'b010));
		send_request(make_request(1000, 500, 500, 1, 1'b1, 3'b001));
	endtask

	task automatic test_random(input int count, input int src_pct, input int snk_pct);
		int per;
		request_t rq;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		repeat (count) begin
			if ($urandom_range(99) < 25) begin
				rq = 72'({$urandom, $urandom, $urandom});
			end else begin
				per = $urandom_range(6) == 0 ? $urandom_range(96000, 1)
					: $urandom_range(750 << $urandom_range(6), 1);
				if (per > 96000) per = 96000;
				rq = make_request(per, $urandom_range(per / 2 + 1, 1),
					$urandom_range(per / 2), $urandom_range(65535), 1'($urandom_range(1)),
					3'($urandom));
			end
			send_request(rq);
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random(280, 0, 0);
		test_random(280, 57, 0);
		test_random(280, 0, 57);
		test_random(285, 30, 30);
		s_axis_tvalid <= 1'b0;
		snk_idle_pct = 0;
		while (pending_settings.size() != 0) @(posedge clk);
		repeat (130) @(posedge clk);
		$display("%0d requests sent, %0d settings checked over four flow-control phases",
			sent, checked);
		$display("%0d mismatches found", errors);
		if (errors == 0 && pending_settings.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
